[design/gcss_pkg.sv]
// shared types, constants and lookup tables for the glyph corner staircase scorer
// no dependencies
`timescale 1ns / 1ps

package gcss_pkg;

  // default profile depth
  localparam int unsigned MaxRowsDef = 128;
  // histogram geometry
  localparam int unsigned HistBins = 256;
  localparam int unsigned HistAw = 8;
  // step counter width (signed, walks are at most a third of the glyph)
  localparam int unsigned StW = 10;
  // left mode bias before the distance compare
  localparam logic [10:0] AbrisOffset = 11'd10;
  // largest fall that still counts as a stair step
  localparam logic signed [8:0] JumpLimit = 9'sd3;
  // table tops
  localparam logic [2:0] StairTop = 3'd5;
  localparam logic [2:0] DistTop = 3'd7;

  // histogram write port
  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] data;
  } hist_wr_t;

  // stair shortfall penalty
  function automatic logic [6:0] stair_pen(input logic [2:0] idx);
    logic [6:0] r;
    case (idx)
      3'd0:    r = 7'd0;
      3'd1:    r = 7'd14;
      3'd2:    r = 7'd36;
      3'd3:    r = 7'd60;
      3'd4:    r = 7'd72;
      default: r = 7'd120;
    endcase
    return r;
  endfunction

  // left/right mode distance penalty
  function automatic logic [7:0] dist_pen(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'd0;
      3'd1:    r = 8'd0;
      3'd2:    r = 8'd12;
      3'd3:    r = 8'd46;
      3'd4:    r = 8'd80;
      3'd5:    r = 8'd120;
      3'd6:    r = 8'd160;
      default: r = 8'd220;
    endcase
    return r;
  endfunction

  // floor(v / 3) by reciprocal multiply, exact for 9-bit v
  function automatic logic [8:0] div3(input logic [8:0] v);
    logic [19:0] p;
    p = 20'(v) * 20'd683;
    return p[19:11];
  endfunction

endpackage

[design/glyph_corner_staircase_scorer.sv]
// glyph corner staircase scorer: row loading, stair walks, mode histograms, sequencer
// depends on gcss_pkg, gcss_prof_mem, gcss_hist, gcss_stair
//
// channel  dir  handshake            payload
// row      in   start & !busy        left_edge_i, right_edge_i, last_row_i
// score    out  valid_o (one cycle)  penalty_u_o, penalty_n_o
//
// a row is taken whenever start is high and busy is low; a row with last_row_i
// starts scoring, and busy stays high through both stair walks, both histogram
// fills and scans and the finishing state.
// after reset the histogram is swept to zero with busy high.
// the result strobe lasts one cycle and cannot be held off.
`timescale 1ns / 1ps

module glyph_corner_staircase_scorer import gcss_pkg::*; #(
  parameter int unsigned MAX_ROWS = MaxRowsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] left_edge_i,
  input  logic [7:0] right_edge_i,
  input  logic       last_row_i,
  output logic       valid_o,
  output logic [6:0] penalty_u_o,
  output logic [8:0] penalty_n_o
);

  localparam int unsigned CW = $clog2(MAX_ROWS + 1);
  localparam int unsigned AW = $clog2(MAX_ROWS);
  localparam int unsigned SW = CW + 2;

  typedef enum logic [11:0] {
    S_CLR    = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_SETUP  = 12'b0000_0000_0100,
    S_RW_RD  = 12'b0000_0000_1000,
    S_RW_USE = 12'b0000_0001_0000,
    S_LW_RD  = 12'b0000_0010_0000,
    S_LW_USE = 12'b0000_0100_0000,
    S_HF_RD  = 12'b0000_1000_0000,
    S_HF_USE = 12'b0001_0000_0000,
    S_HF_INC = 12'b0010_0000_0000,
    S_SCAN   = 12'b0100_0000_0000,
    S_FIN    = 12'b1000_0000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         rows_q, rows_d;
  logic [CW-1:0]         h_q, h_d;
  logic [2:0]            stairs_q, stairs_d;
  logic                  bz_q, bz_d;
  logic signed [SW-1:0]  ez_q, ez_d, lo_q, lo_d, qlo_q, qlo_d, hend_q, hend_d;
  logic signed [SW-1:0]  ptr_q, ptr_d;
  logic [7:0]            prev_q, prev_d;
  logic signed [StW-1:0] st_q, st_d;
  logic                  first_q, first_d;
  logic [6:0]            pen_u_q, pen_u_d, pen_ns_q, pen_ns_d;
  logic [7:0]            ml_q, ml_d, mr_q, mr_d;
  logic                  hist_right_q, hist_right_d;
  logic [8:0]            scan_cnt_q, scan_cnt_d;
  logic [7:0]            best_q, best_d, ans_q, ans_d;
  logic [7:0]            hidx_q, hidx_d;
  logic                  valid_q, valid_d;
  logic [6:0]            pu_q, pu_d;
  logic [8:0]            pn_q, pn_d;

  logic                  accept, store;
  logic [7:0]            rleft, rright, hist_rdata, walk_val, hist_val;
  logic [HistAw-1:0]     hist_raddr;
  hist_wr_t              hist_wr;
  logic signed [StW-1:0] step_st, st_nx, stairs_s;
  logic signed [StW:0]   np;
  logic                  step_stop, stop_nx, walk_right, cont, inb;
  logic signed [SW-1:0]  hs, nxt;
  logic [8:0]            third;
  logic [2:0]            pen_idx;
  logic [6:0]            walk_pen;
  logic [7:0]            ans_fin;
  logic signed [10:0]    mode_diff;
  logic [10:0]           mode_diff_abs;
  logic [2:0]            dist_idx;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign store  = accept && (rows_q < CW'(MAX_ROWS));

  // profile store
  gcss_prof_mem #(.MAX_ROWS(MAX_ROWS)) u_prof (
    .clk_i    (clk_i),
    .we_i     (store),
    .waddr_i  (rows_q[AW-1:0]),
    .wleft_i  (left_edge_i),
    .wright_i (right_edge_i),
    .raddr_i  (ptr_q[AW-1:0]),
    .rleft_o  (rleft),
    .rright_o (rright)
  );

  // histogram
  gcss_hist u_hist (
    .clk_i   (clk_i),
    .wr_i    (hist_wr),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // shared stair step unit
  gcss_stair u_stair (
    .prev_i (prev_q),
    .next_i (walk_val),
    .st_i   (st_q),
    .st_o   (step_st),
    .stop_o (step_stop)
  );

  // walk datapath
  assign walk_right = (state_q == S_RW_USE);
  assign walk_val   = walk_right ? rright : rleft;
  assign hist_val   = hist_right_q ? rright : rleft;
  assign st_nx      = first_q ? st_q : step_st;
  assign stop_nx    = first_q ? 1'b0 : step_stop;
  assign stairs_s   = signed'(StW'(stairs_q));
  assign nxt        = walk_right ? (ptr_q - SW'(1)) : (ptr_q + SW'(1));
  assign inb        = walk_right ? (nxt >= lo_q) : (nxt <= ez_q);
  assign cont       = !stop_nx && inb && (st_nx < stairs_s);

  // shortfall clamp and table lookup
  always_comb begin
    np = signed'((StW + 1)'(stairs_s)) - signed'((StW + 1)'(st_nx));
    if (np > signed'((StW + 1)'(StairTop))) begin
      pen_idx = StairTop;
    end else if (np < 0) begin
      pen_idx = 3'd0;
    end else begin
      pen_idx = np[2:0];
    end
    walk_pen = stair_pen(pen_idx);
  end

  // zone bounds from the height
  assign hs    = signed'(SW'(h_q));
  assign third = div3(9'(h_q));

  // last bin of a scan decides in the finishing cycle
  assign ans_fin = (hist_rdata > best_q) ? 8'(HistBins - 1) : ans_q;

  // distance between the two modes
  always_comb begin
    mode_diff     = signed'({3'b000, ml_q}) - signed'(AbrisOffset) - signed'({3'b000, mr_q});
    mode_diff_abs = (mode_diff < 0) ? 11'(-mode_diff) : 11'(mode_diff);
    dist_idx      = (mode_diff_abs > 11'(DistTop)) ? DistTop : mode_diff_abs[2:0];
  end

  // histogram port control
  always_comb begin
    hist_raddr   = scan_cnt_q[HistAw-1:0];
    hist_wr.we   = 1'b0;
    hist_wr.addr = scan_cnt_q[HistAw-1:0];
    hist_wr.data = '0;
    if (state_q == S_HF_USE) begin
      hist_raddr = hist_val;
    end
    if (state_q == S_HF_INC) begin
      hist_wr.we   = 1'b1;
      hist_wr.addr = hidx_q;
      hist_wr.data = hist_rdata + 8'd1;
    end
    if ((state_q == S_SCAN || state_q == S_CLR) && scan_cnt_q < 9'(HistBins)) begin
      hist_wr.we = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    rows_d       = rows_q;
    h_d          = h_q;
    stairs_d     = stairs_q;
    bz_d         = bz_q;
    ez_d         = ez_q;
    lo_d         = lo_q;
    qlo_d        = qlo_q;
    hend_d       = hend_q;
    ptr_d        = ptr_q;
    prev_d       = prev_q;
    st_d         = st_q;
    first_d      = first_q;
    pen_u_d      = pen_u_q;
    pen_ns_d     = pen_ns_q;
    ml_d         = ml_q;
    mr_d         = mr_q;
    hist_right_d = hist_right_q;
    scan_cnt_d   = scan_cnt_q;
    best_d       = best_q;
    ans_d        = ans_q;
    hidx_d       = hidx_q;
    valid_d      = 1'b0;
    pu_d         = pu_q;
    pn_d         = pn_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (store) begin
            rows_d = rows_q + CW'(1);
          end
          if (last_row_i) begin
            h_d     = store ? (rows_q + CW'(1)) : rows_q;
            rows_d  = '0;
            state_d = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        if (h_q <= 15) begin
          stairs_d = 3'd2;
          bz_d     = 1'b0;
          ez_d     = signed'(SW'(third));
        end else if (h_q <= 24) begin
          stairs_d = 3'd3;
          bz_d     = 1'b0;
          ez_d     = signed'(SW'(third)) + SW'(1);
        end else if (h_q < 40) begin
          stairs_d = 3'd4;
          bz_d     = 1'b0;
          ez_d     = signed'(SW'(third));
        end else begin
          stairs_d = 3'd5;
          bz_d     = 1'b1;
          ez_d     = signed'(SW'(third));
        end
        lo_d    = hs - ez_d + SW'(1);
        ptr_d   = hs - SW'(1) - signed'(SW'(bz_d));
        qlo_d   = signed'(SW'(h_q >> 2));
        hend_d  = hs - signed'(SW'(h_q >> 2));
        st_d    = '0;
        first_d = 1'b1;
        state_d = S_RW_RD;
      end
      S_RW_RD: begin
        state_d = S_RW_USE;
      end
      S_LW_RD: begin
        state_d = S_LW_USE;
      end
      S_RW_USE, S_LW_USE: begin
        prev_d  = walk_val;
        st_d    = st_nx;
        first_d = 1'b0;
        if (cont) begin
          ptr_d   = nxt;
          state_d = walk_right ? S_RW_RD : S_LW_RD;
        end else if (walk_right) begin
          pen_ns_d = walk_pen;
          ptr_d    = signed'(SW'(bz_q));
          st_d     = '0;
          first_d  = 1'b1;
          state_d  = S_LW_RD;
        end else begin
          pen_u_d      = walk_pen;
          hist_right_d = 1'b0;
          ptr_d        = qlo_q;
          scan_cnt_d   = '0;
          best_d       = '0;
          ans_d        = '0;
          state_d      = (qlo_q < hend_q) ? S_HF_RD : S_SCAN;
        end
      end
      S_HF_RD: begin
        state_d = S_HF_USE;
      end
      S_HF_USE: begin
        hidx_d  = hist_val;
        state_d = S_HF_INC;
      end
      S_HF_INC: begin
        if (ptr_q + SW'(1) < hend_q) begin
          ptr_d   = ptr_q + SW'(1);
          state_d = S_HF_RD;
        end else begin
          scan_cnt_d = '0;
          best_d     = '0;
          ans_d      = '0;
          state_d    = S_SCAN;
        end
      end
      S_CLR, S_SCAN: begin
        scan_cnt_d = scan_cnt_q + 9'd1;
        if (scan_cnt_q != 9'd0 && hist_rdata > best_q) begin
          best_d = hist_rdata;
          ans_d  = 8'(scan_cnt_q - 9'd1);
        end
        if (scan_cnt_q == 9'(HistBins)) begin
          scan_cnt_d = '0;
          if (state_q == S_CLR) begin
            state_d = S_IDLE;
          end else if (!hist_right_q) begin
            ml_d         = ans_fin;
            hist_right_d = 1'b1;
            ptr_d        = qlo_q;
            best_d       = '0;
            ans_d        = '0;
            state_d      = (qlo_q < hend_q) ? S_HF_RD : S_SCAN;
          end else begin
            mr_d    = ans_fin;
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        valid_d = 1'b1;
        pu_d    = pen_u_q;
        pn_d    = 9'(pen_ns_q) + 9'(dist_pen(dist_idx));
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      rows_q       <= '0;
      scan_cnt_q   <= '0;
      hist_right_q <= 1'b0;
      first_q      <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      rows_q       <= rows_d;
      scan_cnt_q   <= scan_cnt_d;
      hist_right_q <= hist_right_d;
      first_q      <= first_d;
      valid_q      <= valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    h_q      <= h_d;
    stairs_q <= stairs_d;
    bz_q     <= bz_d;
    ez_q     <= ez_d;
    lo_q     <= lo_d;
    qlo_q    <= qlo_d;
    hend_q   <= hend_d;
    ptr_q    <= ptr_d;
    prev_q   <= prev_d;
    st_q     <= st_d;
    pen_u_q  <= pen_u_d;
    pen_ns_q <= pen_ns_d;
    ml_q     <= ml_d;
    mr_q     <= mr_d;
    best_q   <= best_d;
    ans_q    <= ans_d;
    hidx_q   <= hidx_d;
    pu_q     <= pu_d;
    pn_q     <= pn_d;
  end

  assign valid_o     = valid_q;
  assign penalty_u_o = pu_q;
  assign penalty_n_o = pn_q;

  // result strobe only comes out when the block is ready for rows again
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy)
    else $error("result transfer while scoring still busy");

  // row count never passes the profile depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) rows_q <= CW'(MAX_ROWS))
    else $error("row count beyond profile depth");

  // the finishing state always leads to a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> valid_o)
    else $error("finishing state without result transfer");

  // scan counter stays within the histogram sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni) scan_cnt_q <= 9'(HistBins))
    else $error("histogram sweep counter overrun");

endmodule

[design/gcss_prof_mem.sv]
// left and right edge profile memories, one write and one shared read address
// depends on gcss_pkg
`timescale 1ns / 1ps

module gcss_prof_mem import gcss_pkg::*; #(
  parameter int unsigned MAX_ROWS = MaxRowsDef,
  localparam int unsigned AW = $clog2(MAX_ROWS)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wleft_i,
  input  logic [7:0]    wright_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rleft_o,
  output logic [7:0]    rright_o
);

  logic [7:0] left_mem [MAX_ROWS];
  logic [7:0] right_mem [MAX_ROWS];
  logic [7:0] rleft_q, rright_q;

  // row store and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      left_mem[waddr_i]  <= wleft_i;
      right_mem[waddr_i] <= wright_i;
    end
    rleft_q  <= left_mem[raddr_i];
    rright_q <= right_mem[raddr_i];
  end

  assign rleft_o  = rleft_q;
  assign rright_o = rright_q;

endmodule

[design/gcss_hist.sv]
// 256-bin mode histogram memory, one write port and one registered read port
// depends on gcss_pkg
`timescale 1ns / 1ps

module gcss_hist import gcss_pkg::*; (
  input  logic              clk_i,
  input  hist_wr_t          wr_i,
  input  logic [HistAw-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] bin_mem [HistBins];
  logic [7:0] rdata_q;

  // count update and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      bin_mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= bin_mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/gcss_stair.sv]
// one stair rule step between two neighboring profile values
// depends on gcss_pkg
`timescale 1ns / 1ps

module gcss_stair import gcss_pkg::*; (
  input  logic [7:0]            prev_i,
  input  logic [7:0]            next_i,
  input  logic signed [StW-1:0] st_i,
  output logic signed [StW-1:0] st_o,
  output logic                  stop_o
);

  logic signed [8:0] fall;

  // fall = prev - next; rise = -fall
  always_comb begin
    fall   = signed'({1'b0, prev_i}) - signed'({1'b0, next_i});
    st_o   = st_i;
    stop_o = 1'b0;
    if (fall > JumpLimit) begin
      st_o = '0;
    end else if (fall < -9'sd1) begin
      st_o   = '0;
      stop_o = 1'b1;
    end else if (fall == -9'sd1) begin
      st_o = st_i - StW'(1);
    end else if (fall == 9'sd0) begin
      st_o = st_i;
    end else begin
      st_o = st_i + StW'(1);
    end
  end

endmodule

[dv/tb_glyph_corner_staircase_scorer.sv]
// self-checking testbench for the glyph corner staircase scorer
// depends on gcss_pkg and glyph_corner_staircase_scorer
`timescale 1ns / 1ps

module tb_glyph_corner_staircase_scorer;
  import gcss_pkg::*;

  localparam int unsigned MAX_ROWS = MaxRowsDef;
  localparam int unsigned LIMIT = 3000000;

  typedef struct packed {
    logic [7:0] left_edge;
    logic [7:0] right_edge;
    logic       last_row;
  } row_t;

  typedef struct packed {
    logic [6:0] pen_u;
    logic [8:0] pen_n;
  } score_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] left_edge_i = '0;
  logic [7:0] right_edge_i = '0;
  logic       last_row_i = 1'b0;
  logic       valid_o;
  logic [6:0] penalty_u_o;
  logic [8:0] penalty_n_o;

  glyph_corner_staircase_scorer #(.MAX_ROWS(MAX_ROWS)) uut (
    .clk_i, .rst_ni, .start, .busy, .left_edge_i, .right_edge_i, .last_row_i,
    .valid_o, .penalty_u_o, .penalty_n_o
  );

  always #10 clk_i = ~clk_i;

  row_t   pending_rows[$];
  score_t expected_scores[$];
  int     idle_pct = 0;
  bit     stim_done = 1'b0;
  int     mismatches = 0;
  int     cycles = 0;

  // predictor state
  logic [7:0] left_prof[MAX_ROWS];
  logic [7:0] right_prof[MAX_ROWS];
  int         rows_held = 0;

  // one stair rule step, returns 0 when the walk stops
  function automatic bit stair_rule(int prv, int nxt, ref int st);
    int d;
    d = nxt - prv;
    if (prv - nxt > 3) begin
      st = 0;
      return 1'b1;
    end
    if (d > 1) begin
      st = 0;
      return 1'b0;
    end
    if (d == 1) st--;
    else if (d != 0) st++;
    return 1'b1;
  endfunction

  function automatic int stair_cost(int stairs, int st);
    int np;
    int tbl[6] = '{0, 14, 36, 60, 72, 120};
    np = stairs - st;
    if (np > 5) np = 5;
    if (np < 0) np = 0;
    return tbl[np];
  endfunction

  function automatic int prof_val(bit right, int i);
    if (i < 0 || i >= MAX_ROWS) return 0;
    return right ? int'(right_prof[i]) : int'(left_prof[i]);
  endfunction

  // most frequent value, smallest on ties
  function automatic int mode_of(bit right, int lo, int hi);
    int cnt[256];
    int best, ans;
    best = 0;
    ans = 0;
    foreach (cnt[k]) cnt[k] = 0;
    for (int i = lo; i < hi; i++) cnt[prof_val(right, i) & 255]++;
    for (int i = 0; i < 256; i++)
      if ((cnt[i] & 255) > best) begin
        best = cnt[i] & 255;
        ans = i;
      end
    return ans;
  endfunction

  function automatic score_t glyph_score(int h);
    int stairs, bz, ez, lo, hi, st, q, dd, pu, pn;
    int dtbl[8] = '{0, 0, 12, 46, 80, 120, 160, 220};
    score_t r;
    if (h < 40 && h > 24) begin
      stairs = 4; bz = 0; ez = h / 3;
    end else if (h <= 24 && h > 15) begin
      stairs = 3; bz = 0; ez = h / 3 + 1;
    end else if (h <= 15) begin
      stairs = 2; bz = 0; ez = h / 3;
    end else begin
      stairs = 5; bz = 1; ez = h / 3;
    end
    // upper right, downward
    lo = h - ez + 1;
    hi = h - 1 - bz;
    st = 0;
    for (int c = hi - 1; c >= lo && st < stairs; c--)
      if (!stair_rule(prof_val(1, c + 1), prof_val(1, c), st)) break;
    pn = stair_cost(stairs, st);
    // bottom left, upward
    st = 0;
    for (int c = bz + 1; c <= ez && st < stairs; c++)
      if (!stair_rule(prof_val(0, c - 1), prof_val(0, c), st)) break;
    pu = stair_cost(stairs, st);
    q = h >> 2;
    dd = (mode_of(0, q, h - q) - 10) - mode_of(1, q, h - q);
    if (dd < 0) dd = -dd;
    if (dd > 7) dd = 7;
    pn += dtbl[dd];
    r.pen_u = 7'(pu);
    r.pen_n = 9'(pn);
    return r;
  endfunction

  // update predictor with one accepted row
  task automatic predict_row(row_t it);
    if (rows_held < MAX_ROWS) begin
      left_prof[rows_held] = it.left_edge;
      right_prof[rows_held] = it.right_edge;
      rows_held++;
    end
    if (it.last_row) begin
      expected_scores.push_back(glyph_score(rows_held));
      rows_held = 0;
    end
  endtask

  // driver: present rows at the falling edge, transfer at the rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pending_rows.size() > 0 && ($urandom_range(99) >= idle_pct)) begin
        start <= 1'b1;
        left_edge_i <= pending_rows[0].left_edge;
        right_edge_i <= pending_rows[0].right_edge;
        last_row_i <= pending_rows[0].last_row;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // transfer detection and result check at the rising edge
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && start && !busy) begin
      predict_row(pending_rows.pop_front());
    end
    if (rst_ni && valid_o) begin
      if (expected_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected score u=%0d n=%0d", penalty_u_o, penalty_n_o);
      end else begin
        score_t e;
        e = expected_scores.pop_front();
        if (e.pen_u !== penalty_u_o || e.pen_n !== penalty_n_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("score mismatch: exp u=%0d n=%0d got u=%0d n=%0d",
                     e.pen_u, e.pen_n, penalty_u_o, penalty_n_o);
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("tb_glyph_corner_staircase_scorer NOT OK");
      $finish;
    end
  end

  // one glyph of h rows; kind picks the profile shape
  task automatic add_glyph(int h, int kind);
    int l, r;
    l = $urandom_range(255);
    r = $urandom_range(255);
    for (int i = 0; i < h; i++) begin
      row_t it;
      case (kind)
        0: begin
          l = $urandom_range(255);
          r = $urandom_range(255);
        end
        1: begin
          // staircase-like edges with small steps
          l = (l + $urandom_range(4) - 2) & 255;
          r = (r + $urandom_range(5) - 3) & 255;
        end
        default: begin
          l = ($urandom_range(3) == 0) ? 255 : l;
          r = ($urandom_range(3) == 0) ? 255 : ((l + 246 + $urandom_range(4)) & 255);
        end
      endcase
      it.left_edge = 8'(l);
      it.right_edge = 8'(r);
      it.last_row = (i == h - 1);
      pending_rows.push_back(it);
    end
  endtask

  task automatic drain;
    while (pending_rows.size() > 0 || expected_scores.size() > 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  int total;

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: single-row glyphs, heights at zone edges, an overflowing glyph
    begin
      row_t it;
      it = '{8'd0, 8'd255, 1'b1};
      pending_rows.push_back(it);
      it = '{8'd255, 8'd0, 1'b1};
      pending_rows.push_back(it);
    end
    add_glyph(15, 1);
    add_glyph(16, 1);
    add_glyph(24, 2);
    add_glyph(25, 1);
    add_glyph(40, 1);
    add_glyph(MAX_ROWS + 3, 0);
    drain();
    // random glyphs over idling phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 85 : (ph == 2) ? 0 : 38;
      total = 0;
      while (total < 190) begin
        int h;
        h = ($urandom_range(19) == 0) ? $urandom_range(MAX_ROWS + 4, 40)
                                      : $urandom_range(45, 1);
        add_glyph(h, $urandom_range(9) < 6 ? 1 : $urandom_range(2));
        total += h;
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("tb_glyph_corner_staircase_scorer OK");
    end else begin
      $display("tb_glyph_corner_staircase_scorer NOT OK");
    end
    $finish;
  end

endmodule
